>>> hdl/dalm_pkg.sv
package dalm_pkg;

  // Field widths.
  localparam int TIME_W  = 56;
  localparam int TICK_W  = 40;
  localparam int SCALE_W = 16;
  localparam int BANK_W  = 4;
  localparam int KIND_W  = 3;

  // The tick count is split in two for the scale multiplication.
  localparam int TICK_LO_W = 24;
  localparam int TICK_HI_W = TICK_W - TICK_LO_W;

  // Default configuration and sizing.
  localparam int BANK_COUNT_DEF = 8;
  localparam int MID_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF  = 4;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

  // Command kinds.
  localparam logic [KIND_W-1:0] CMD_ACT   = 3'd0;
  localparam logic [KIND_W-1:0] CMD_RD    = 3'd1;
  localparam logic [KIND_W-1:0] CMD_RDA   = 3'd2;
  localparam logic [KIND_W-1:0] CMD_WR    = 3'd3;
  localparam logic [KIND_W-1:0] CMD_WRA   = 3'd4;
  localparam logic [KIND_W-1:0] CMD_OTHER = 3'd5;

  // Classified command between the front and the back.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [BANK_W-1:0] bank;
    logic              is_act;
  } mid_item_t;

  // One result.
  typedef struct packed {
    logic [TIME_W-1:0] latency;
    logic [TIME_W-1:0] interval_start;
    logic [TIME_W-1:0] interval_length;
    logic [TIME_W-1:0] min_latency;
    logic [TIME_W-1:0] max_latency;
  } result_t;

  // Occupancy of the back pipeline stages.
  typedef struct packed {
    logic stage1;
    logic stage2;
  } back_busy_t;

endpackage

>>> hdl/dalm_queue.sv
module dalm_queue #(
  parameter int DEPTH = dalm_pkg::MID_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign do_push = push;
  assign do_pop  = pop && (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

  // Storage array.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/dalm_front.sv
module dalm_front #(
  parameter int BANK_COUNT = dalm_pkg::BANK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr,
  input  logic [dalm_pkg::SCALE_W-1:0]  cfg_data,
  input  logic                          accept,
  input  logic [dalm_pkg::TICK_W-1:0]   ticks,
  input  logic [dalm_pkg::BANK_W-1:0]   bank,
  input  logic [dalm_pkg::KIND_W-1:0]   kind,
  output logic                          item_valid,
  output dalm_pkg::mid_item_t           item
);
  import dalm_pkg::*;

  localparam int PROD_LO_W = TICK_LO_W + SCALE_W;
  localparam int PROD_HI_W = TICK_HI_W + SCALE_W;

  logic [SCALE_W-1:0]           scale_r;
  logic                         valid_r;
  logic [TICK_LO_W+SCALE_W-1:0] prod_lo_r;
  logic [TICK_HI_W+SCALE_W-1:0] prod_hi_r;
  logic [BANK_W-1:0]            bank_r;
  logic                         is_act_r;
  logic                         bank_ok;
  logic                         kind_ok;

  // Scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr) begin
      scale_r <= cfg_data;
    end
  end

  // Only activates and column commands to banks in range reach the back.
  always_comb begin
    bank_ok = ({1'b0, bank} < (BANK_W + 1)'(BANK_COUNT));
    kind_ok = (kind inside {CMD_ACT, CMD_RD, CMD_RDA, CMD_WR, CMD_WRA});
  end

  // Valid flag of the multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept && bank_ok && kind_ok;
    end
  end

  // Two partial products of the tick-to-picosecond scaling.
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_lo_r <= PROD_LO_W'(ticks[TICK_LO_W-1:0]) * PROD_LO_W'(scale_r);
      prod_hi_r <= PROD_HI_W'(ticks[TICK_W-1:TICK_LO_W]) * PROD_HI_W'(scale_r);
      bank_r    <= bank;
      is_act_r  <= (kind == CMD_ACT);
    end
  end

  // Sum of the partial products, truncated to the time width.
  assign item_valid  = valid_r;
  assign item.now    = TIME_W'(prod_lo_r) + {prod_hi_r, {TICK_LO_W{1'b0}}};
  assign item.bank   = bank_r;
  assign item.is_act = is_act_r;

endmodule

>>> hdl/dalm_back.sv
module dalm_back #(
  parameter int BANK_COUNT = dalm_pkg::BANK_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  dalm_pkg::mid_item_t  item,
  output dalm_pkg::back_busy_t busy,
  output logic                 res_valid,
  output dalm_pkg::result_t    res
);
  import dalm_pkg::*;

  localparam int IDX_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  logic [TIME_W-1:0] act_r [BANK_COUNT];
  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] min_r;
  logic [TIME_W-1:0] max_r;
  logic [TIME_W-1:0] min_nxt;
  logic [TIME_W-1:0] max_nxt;
  logic              b1_valid_r;
  logic [TIME_W-1:0] b1_latency_r;
  logic [TIME_W-1:0] b1_start_r;
  logic [TIME_W-1:0] b1_length_r;
  logic              b2_valid_r;
  result_t           b2_r;
  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] act_sel;
  logic              emit;

  // Activate table lookup; a stored zero means no activate.
  always_comb begin
    idx     = item.bank[IDX_W-1:0];
    act_sel = act_r[idx];
    emit    = take && !item.is_act && (act_sel != '0);
  end

  // Activate table, previous result time and stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANK_COUNT; i++) begin
        act_r[i] <= '0;
      end
      prev_r     <= '0;
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
    end else begin
      if (take && item.is_act) begin
        act_r[idx] <= item.now;
      end else if (emit) begin
        act_r[idx] <= '0;
      end
      if (emit) begin
        prev_r <= item.now;
      end
      b1_valid_r <= emit;
      b2_valid_r <= b1_valid_r;
    end
  end

  // Stage one: latency and interval.
  always_ff @(posedge clk) begin
    if (emit) begin
      b1_latency_r <= item.now - act_sel;
      b1_start_r   <= prev_r;
      b1_length_r  <= item.now - prev_r;
    end
  end

  // Running extremes including the current latency.
  always_comb begin
    min_nxt = (b1_latency_r < min_r) ? b1_latency_r : min_r;
    max_nxt = (b1_latency_r > max_r) ? b1_latency_r : max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '1;
      max_r <= '0;
    end else if (b1_valid_r) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // Stage two: finished result.
  always_ff @(posedge clk) begin
    if (b1_valid_r) begin
      b2_r.latency         <= b1_latency_r;
      b2_r.interval_start  <= b1_start_r;
      b2_r.interval_length <= b1_length_r;
      b2_r.min_latency     <= min_nxt;
      b2_r.max_latency     <= max_nxt;
    end
  end

  assign busy.stage1 = b1_valid_r;
  assign busy.stage2 = b2_valid_r;
  assign res_valid   = b2_valid_r;
  assign res         = b2_r;

endmodule

>>> hdl/dram_act_to_column_latency_monitor.sv
// Activate-to-column latency monitor. Push one decoded DRAM command per clock (timestamp in
// ticks, bank, kind); the block takes a new command every cycle as long as the result queue
// is drained. Each read or write that hits a bank with a recorded activate yields one result,
// popped from the out_ side after it has passed the tick-to-picosecond multiply, the command
// queue, the two latency and min/max stages and the result queue. The one-per-cycle rate is
// set by the activate table, which is read and updated by a single stage each clock. Scale
// writes on cfg_ are accepted at any time but must only be made while no command is in flight.
// No clearing pass follows reset.
module dram_act_to_column_latency_monitor #(
  parameter int BANK_COUNT = dalm_pkg::BANK_COUNT_DEF,
  parameter int MID_DEPTH  = dalm_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH  = dalm_pkg::OUT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dalm_pkg::SCALE_W-1:0]  cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [dalm_pkg::TICK_W-1:0]   in_timestamp_ticks,
  input  logic [dalm_pkg::BANK_W-1:0]   in_bank,
  input  logic [dalm_pkg::KIND_W-1:0]   in_command_kind,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [dalm_pkg::TIME_W-1:0]   out_latency_ps,
  output logic [dalm_pkg::TIME_W-1:0]   out_interval_start_ps,
  output logic [dalm_pkg::TIME_W-1:0]   out_interval_length_ps,
  output logic [dalm_pkg::TIME_W-1:0]   out_min_latency_ps,
  output logic [dalm_pkg::TIME_W-1:0]   out_max_latency_ps
);
  import dalm_pkg::*;

  localparam int MID_CW = $clog2(MID_DEPTH + 1);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
  localparam int MID_W  = $bits(mid_item_t);
  localparam int RES_W  = $bits(result_t);

  logic              accept;
  logic              front_valid;
  mid_item_t         front_item;
  logic              mid_empty;
  logic [MID_CW-1:0] mid_count;
  logic [MID_W-1:0]  mid_rdata;
  mid_item_t         mid_head;
  logic              back_take;
  back_busy_t        back_busy;
  logic              res_valid;
  result_t           res;
  logic [RES_W-1:0]  out_rdata;
  result_t           out_head;
  logic [OUT_CW-1:0] out_count;
  logic [OUT_CW+1:0] out_pending;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // Credit check: the command queue must hold everything in the multiply stage.
  assign in_full = ({1'b0, mid_count} + (MID_CW + 1)'(front_valid))
                   >= (MID_CW + 1)'(MID_DEPTH);

  dalm_front #(
    .BANK_COUNT (BANK_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .ticks      (in_timestamp_ticks),
    .bank       (in_bank),
    .kind       (in_command_kind),
    .item_valid (front_valid),
    .item       (front_item)
  );

  dalm_queue #(
    .DEPTH (MID_DEPTH),
    .WIDTH (MID_W)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_valid),
    .wdata (front_item),
    .pop   (back_take),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign mid_head = mid_rdata;

  // Credit check: the result queue must hold everything in the back stages.
  assign out_pending = (OUT_CW + 2)'(out_count) + (OUT_CW + 2)'(back_busy.stage1)
                       + (OUT_CW + 2)'(back_busy.stage2);
  assign back_take   = !mid_empty && (out_pending < (OUT_CW + 2)'(OUT_DEPTH));

  dalm_back #(
    .BANK_COUNT (BANK_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (back_take),
    .item      (mid_head),
    .busy      (back_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  dalm_queue #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty),
    .count (out_count)
  );

  // Result ports.
  assign out_head               = out_rdata;
  assign out_latency_ps         = out_head.latency;
  assign out_interval_start_ps  = out_head.interval_start;
  assign out_interval_length_ps = out_head.interval_length;
  assign out_min_latency_ps     = out_head.min_latency;
  assign out_max_latency_ps     = out_head.max_latency;

  // The command queue is never written while it holds MID_DEPTH items.
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> (mid_count < MID_CW'(MID_DEPTH)))
    else $error("command queue overflow");

  // The result queue is never written while it holds OUT_DEPTH items.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (out_count < OUT_CW'(OUT_DEPTH)))
    else $error("result queue overflow");

  // A finished result lies between its own running extremes.
  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((res.min_latency <= res.latency) && (res.latency <= res.max_latency)))
    else $error("result outside running min/max");

  // A result leaves the back after its taken command has passed stage one and stage two.
  a_back_timing: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(back_take, 2))
    else $error("result without a taken command");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dalm_pkg::*;

  localparam int BANKS = BANK_COUNT_DEF;
  localparam logic [KIND_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] CMD_RSVD7 = 3'd7;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [SCALE_W-1:0] SCALE_ZERO = '0;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  // Cycles to let commands that cause no result leave the pipeline.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT_NS = 2_000_000;

  // Tracks activates per bank and predicts the latency report of each column command.
  class act_column_tracker;
    logic [SCALE_W-1:0] scale;
    logic [TIME_W-1:0] act_time [BANKS];
    logic [TIME_W-1:0] last_report_ps;
    logic [TIME_W-1:0] min_seen_ps;
    logic [TIME_W-1:0] max_seen_ps;
    result_t due_reports [$];
    int errors;

    function new();
      scale = SCALE_RESET;
      foreach (act_time[b]) act_time[b] = '0;
      last_report_ps = '0;
      min_seen_ps = '1;
      max_seen_ps = '0;
      errors = 0;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] value);
      scale = value;
    endfunction

    // Update the bank table for one accepted command and queue any report it causes.
    function void note_command(logic [TICK_W-1:0] ticks, logic [BANK_W-1:0] bank,
                               logic [KIND_W-1:0] kind);
      logic [TIME_W-1:0] now_ps;
      logic [TIME_W-1:0] lat_ps;
      result_t report;
      now_ps = TIME_W'(ticks) * TIME_W'(scale);
      if (bank >= BANKS) return;
      if (kind == CMD_ACT) begin
        act_time[bank] = now_ps;
        return;
      end
      if (kind > CMD_WRA) return;
      // A stored time of zero means the bank holds no activate.
      if (act_time[bank] == '0) return;
      lat_ps = now_ps - act_time[bank];
      if (lat_ps < min_seen_ps) min_seen_ps = lat_ps;
      if (lat_ps > max_seen_ps) max_seen_ps = lat_ps;
      report.latency = lat_ps;
      report.interval_start = last_report_ps;
      report.interval_length = now_ps - last_report_ps;
      report.min_latency = min_seen_ps;
      report.max_latency = max_seen_ps;
      due_reports.insert(due_reports.size(), report);
      last_report_ps = now_ps;
      act_time[bank] = '0;
    endfunction

    task report_error(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    // Compare one popped report against the oldest prediction.
    task check_report(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        report_error("report popped while none was outstanding");
        return;
      end
      want = due_reports.pop_front();
      if (got.latency !== want.latency)
        report_error($sformatf("latency_ps got %0d want %0d", got.latency, want.latency));
      if (got.interval_start !== want.interval_start)
        report_error($sformatf("interval_start_ps got %0d want %0d",
                               got.interval_start, want.interval_start));
      if (got.interval_length !== want.interval_length)
        report_error($sformatf("interval_length_ps got %0d want %0d",
                               got.interval_length, want.interval_length));
      if (got.min_latency !== want.min_latency)
        report_error($sformatf("min_latency_ps got %0d want %0d",
                               got.min_latency, want.min_latency));
      if (got.max_latency !== want.max_latency)
        report_error($sformatf("max_latency_ps got %0d want %0d",
                               got.max_latency, want.max_latency));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [TICK_W-1:0] in_timestamp_ticks = '0;
  logic [BANK_W-1:0] in_bank = '0;
  logic [KIND_W-1:0] in_command_kind = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [TIME_W-1:0] out_latency_ps;
  logic [TIME_W-1:0] out_interval_start_ps;
  logic [TIME_W-1:0] out_interval_length_ps;
  logic [TIME_W-1:0] out_min_latency_ps;
  logic [TIME_W-1:0] out_max_latency_ps;

  act_column_tracker tracker = new();
  int send_idle_pct = 14;
  int recv_idle_pct = 54;
  int hold_request = 0;
  logic [TICK_W-1:0] tick_now = '0;

  dram_act_to_column_latency_monitor u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_timestamp_ticks     (in_timestamp_ticks),
    .in_bank                (in_bank),
    .in_command_kind        (in_command_kind),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_latency_ps         (out_latency_ps),
    .out_interval_start_ps  (out_interval_start_ps),
    .out_interval_length_ps (out_interval_length_ps),
    .out_min_latency_ps     (out_min_latency_ps),
    .out_max_latency_ps     (out_max_latency_ps)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // A hard limit on the run in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

  // Pop side: random stalls plus an occasional long hold-off counted here.
  initial begin : report_sink
    int hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        tracker.check_report('{out_latency_ps, out_interval_start_ps, out_interval_length_ps,
                               out_min_latency_ps, out_max_latency_ps});
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one command, with a random gap first, and hold it until the transfer happens.
  // The push line stays high afterwards so back-to-back transfers need no toggle.
  task automatic send_cmd(logic [TICK_W-1:0] ticks, logic [BANK_W-1:0] bank,
                          logic [KIND_W-1:0] kind);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_timestamp_ticks <= ticks;
    in_bank <= bank;
    in_command_kind <= kind;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.note_command(ticks, bank, kind);
  endtask

  // Stop pushing and wait until every predicted report has been popped.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The scale is only changed with nothing in flight.
  task automatic write_scale(logic [SCALE_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_scale(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small forward steps, sometimes a long jump or a step backwards.
  task automatic step_time();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      tick_now = TICK_W'({$urandom(), $urandom()});
    end else if (roll < 5) begin
      tick_now = tick_now - TICK_W'($urandom_range(1, 200));
    end else begin
      tick_now = tick_now + TICK_W'($urandom_range(0, 40));
    end
  endtask

  // Activate then column command on one bank, with noise between, plus stray commands.
  task automatic run_random(int count);
    int done_cnt;
    int noise_cnt;
    logic [BANK_W-1:0] bank;
    logic [KIND_W-1:0] kind;
    done_cnt = 0;
    while (done_cnt < count) begin
      if ($urandom_range(99) < 80) begin
        bank = BANK_W'($urandom_range(BANKS - 1));
        step_time();
        send_cmd(tick_now, bank, CMD_ACT);
        noise_cnt = $urandom_range(3);
        repeat (noise_cnt) begin
          step_time();
          send_cmd(tick_now, BANK_W'($urandom_range(15)), KIND_W'($urandom_range(7)));
        end
        step_time();
        send_cmd(tick_now, bank, KIND_W'($urandom_range(CMD_RD, CMD_WRA)));
        done_cnt += 2;
      end else begin
        bank = BANK_W'($urandom_range(15));
        kind = KIND_W'($urandom_range(7));
        step_time();
        send_cmd(tick_now, bank, kind);
        if (bank < BANKS && kind <= CMD_WRA) done_cnt++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands at the widest scale.
    write_scale(SCALE_MAX);
    send_cmd(40'd2, 4'd0, CMD_RD);
    send_cmd(40'd0, 4'd0, CMD_ACT);
    send_cmd(40'd5, 4'd0, CMD_RD);
    send_cmd(40'd1, 4'd1, CMD_ACT);
    send_cmd(40'd3, 4'd1, CMD_RD);
    send_cmd(40'd10, 4'd2, CMD_ACT);
    send_cmd(40'd20, 4'd2, CMD_ACT);
    send_cmd(40'd25, 4'd2, CMD_RDA);
    send_cmd(40'd30, 4'd7, CMD_ACT);
    send_cmd(40'd31, 4'd7, CMD_WR);
    send_cmd(40'd40, 4'd3, CMD_ACT);
    send_cmd(40'd100, 4'd3, CMD_WRA);
    send_cmd(40'd50, 4'd8, CMD_ACT);
    send_cmd(40'd50, 4'd15, CMD_ACT);
    send_cmd(40'd55, 4'd15, CMD_RD);
    send_cmd(40'd60, 4'd4, CMD_ACT);
    send_cmd(40'd61, 4'd4, CMD_OTHER);
    send_cmd(40'd62, 4'd4, CMD_RSVD6);
    send_cmd(40'd63, 4'd4, CMD_RSVD7);
    send_cmd(40'd64, 4'd4, CMD_RD);
    send_cmd(TICK_MAX, 4'd5, CMD_ACT);
    send_cmd(TICK_MAX, 4'd5, CMD_WR);
    send_cmd(40'd1000, 4'd6, CMD_ACT);
    send_cmd(40'd5, 4'd6, CMD_RD);
    send_cmd(40'd1, 4'd0, CMD_ACT);
    send_cmd(TICK_MAX, 4'd0, CMD_WRA);

    // Sender mostly busy, receiver often stalled, unit scale.
    send_idle_pct = 14;
    recv_idle_pct = 54;
    write_scale(SCALE_RESET);
    run_random(65);

    // Sender often idle, receiver mostly ready, with a full drain halfway.
    send_idle_pct = 54;
    recv_idle_pct = 14;
    write_scale(SCALE_W'($urandom_range(2, 65535)));
    run_random(32);
    wait_idle();
    run_random(32);

    // A zero scale records no activate, so nothing comes out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_scale(SCALE_ZERO);
    run_random(10);

    // No idling; a long pop hold-off first so the input side backs up.
    write_scale(SCALE_W'($urandom_range(1, 1000)));
    hold_request = HOLD_CYCLES;
    run_random(70);

    wait_idle();
    if (tracker.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
